// ===== hdl/ntnh_pkg.sv =====
`default_nettype none
package ntnh_pkg;

    // default sizes
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int TRUST_FRAC_DEF    = 10;

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRUST_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRUST_INCREMENT  = 2'd2;

    localparam logic [15:0] ENERGY_THRESHOLD_RST = 16'd10;
    localparam logic [10:0] TRUST_THRESHOLD_RST  = 11'd512;
    localparam logic [10:0] TRUST_INCREMENT_RST  = 11'd10;

    // update status codes
    localparam logic [1:0] STATUS_UPDATED = 2'd0;
    localparam logic [1:0] STATUS_ADDED   = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [15:0] neighbor_address;
        logic [15:0] neighbor_energy;
        logic [10:0] neighbor_trust;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  update_status;
        logic        low_energy;
        logic        route_found;
        logic [15:0] hop_address;
        logic [3:0]  hop_index;
        logic [25:0] hop_score;
        logic [4:0]  neighbor_total;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic look;
        logic write;
        logic scan;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic look_done;
        logic scan_done;
    } stat_t;

endpackage
`default_nettype wire

// ===== hdl/ntnh_datapath.sv =====
`default_nettype none
module ntnh_datapath #(
    parameter int TABLE_ENTRIES       = ntnh_pkg::TABLE_ENTRIES_DEF,
    parameter int TRUST_FRACTION_BITS = ntnh_pkg::TRUST_FRAC_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  ntnh_pkg::cmd_t                     cmd,
    output ntnh_pkg::stat_t                    stat,
    input  ntnh_pkg::in_item_t                 in_data,
    input  wire                                cfg_we,
    input  wire [ntnh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [ntnh_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ntnh_pkg::out_item_t                out_data
);

    localparam int IW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW        = $clog2(TABLE_ENTRIES + 1);
    localparam int TW        = (TRUST_FRACTION_BITS >= 11) ? 12 : TRUST_FRACTION_BITS + 1;
    localparam int SCW       = TW + 16;
    localparam int TRUST_ONE = 1 << TRUST_FRACTION_BITS;

    // neighbor table memories
    logic [15:0]   tbl_address [TABLE_ENTRIES];
    logic [TW-1:0] tbl_trust   [TABLE_ENTRIES];
    logic [15:0]   tbl_energy  [TABLE_ENTRIES];

    // configuration
    logic [15:0] energy_thr_reg;
    logic [10:0] trust_thr_reg;
    logic [10:0] trust_inc_reg;

    // control state
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic          hit_reg;
    logic          p1_vld_reg;
    logic          s2_vld_reg;
    logic          found_reg;

    // payload state
    ntnh_pkg::in_item_t  in_reg;
    ntnh_pkg::out_item_t out_reg;
    logic [IW-1:0]  slot_reg;
    logic [1:0]     status_reg;
    logic [15:0]    rd_address_reg;
    logic [TW-1:0]  rd_trust_reg;
    logic [15:0]    rd_energy_reg;
    logic [IW-1:0]  p1_idx_reg;
    logic [SCW-1:0] s2_score_reg;
    logic           s2_elig_reg;
    logic [IW-1:0]  s2_idx_reg;
    logic [15:0]    s2_address_reg;
    logic [SCW-1:0] best_score_reg;
    logic [IW-1:0]  best_slot_reg;
    logic [15:0]    best_address_reg;

    logic           issue;
    logic           hit_now;
    logic           full;
    logic           wr_en;
    logic           wr_new;
    logic [IW-1:0]  wr_idx;
    logic [11:0]    trust_sum;
    logic [TW-1:0]  trust_clamped;
    logic [SCW-1:0] product;
    logic           better;

    // read issue, lookup compare and status
    assign issue   = ((cmd.look && !hit_reg) || cmd.scan) && (idx_reg < count_reg);
    assign hit_now = cmd.look && p1_vld_reg && !hit_reg
                     && (rd_address_reg == in_reg.neighbor_address);
    assign stat.look_done = !p1_vld_reg && (hit_reg || (idx_reg == count_reg));
    assign stat.scan_done = !p1_vld_reg && !s2_vld_reg && (idx_reg == count_reg);

    // table update
    assign full      = (count_reg == CW'(TABLE_ENTRIES));
    assign wr_new    = cmd.write && !hit_reg && !full;
    assign wr_en     = cmd.write && (hit_reg || !full);
    assign wr_idx    = hit_reg ? slot_reg : count_reg[IW-1:0];
    assign trust_sum = {1'b0, in_reg.neighbor_trust} + {1'b0, trust_inc_reg};
    assign trust_clamped = (18'(trust_sum) > 18'(TRUST_ONE)) ? TW'(TRUST_ONE)
                                                             : TW'(trust_sum);

    // score and best pick
    assign product = SCW'(rd_trust_reg) * SCW'(rd_energy_reg);
    assign better  = s2_vld_reg && s2_elig_reg && (!found_reg || (s2_score_reg > best_score_reg));

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_trust[wr_idx]  <= trust_clamped;
            tbl_energy[wr_idx] <= in_reg.neighbor_energy;
        end
        if (wr_new) begin
            tbl_address[wr_idx] <= in_reg.neighbor_address;
        end
        rd_address_reg <= tbl_address[idx_reg[IW-1:0]];
        rd_trust_reg   <= tbl_trust[idx_reg[IW-1:0]];
        rd_energy_reg  <= tbl_energy[idx_reg[IW-1:0]];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_thr_reg <= ntnh_pkg::ENERGY_THRESHOLD_RST;
            trust_thr_reg  <= ntnh_pkg::TRUST_THRESHOLD_RST;
            trust_inc_reg  <= ntnh_pkg::TRUST_INCREMENT_RST;
            count_reg      <= '0;
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            p1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    ntnh_pkg::CFG_ENERGY_THRESHOLD: energy_thr_reg <= cfg_data;
                    ntnh_pkg::CFG_TRUST_THRESHOLD:  trust_thr_reg  <= cfg_data[10:0];
                    ntnh_pkg::CFG_TRUST_INCREMENT:  trust_inc_reg  <= cfg_data[10:0];
                    default: ;
                endcase
            end
            p1_vld_reg <= issue;
            s2_vld_reg <= cmd.scan && p1_vld_reg;
            if (issue) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (hit_now) begin
                hit_reg <= 1'b1;
            end
            if (better) begin
                found_reg <= 1'b1;
            end
            if (cmd.start) begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            if (cmd.write) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                if (wr_new) begin
                    count_reg <= count_reg + CW'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            in_reg <= in_data;
        end
        if (issue) begin
            p1_idx_reg <= idx_reg[IW-1:0];
        end
        if (hit_now) begin
            slot_reg <= p1_idx_reg;
        end
        if (cmd.write) begin
            status_reg <= hit_reg ? ntnh_pkg::STATUS_UPDATED
                        : (full ? ntnh_pkg::STATUS_FULL : ntnh_pkg::STATUS_ADDED);
        end
        s2_score_reg   <= product;
        s2_elig_reg    <= (12'(rd_trust_reg) > 12'(trust_thr_reg))
                          && (rd_energy_reg > energy_thr_reg);
        s2_idx_reg     <= p1_idx_reg;
        s2_address_reg <= rd_address_reg;
        if (better) begin
            best_score_reg   <= s2_score_reg;
            best_slot_reg    <= s2_idx_reg;
            best_address_reg <= s2_address_reg;
        end
        if (cmd.finish) begin
            out_reg.update_status  <= status_reg;
            out_reg.low_energy     <= (in_reg.neighbor_energy < energy_thr_reg);
            out_reg.route_found    <= found_reg;
            out_reg.hop_address    <= found_reg ? best_address_reg : 16'd0;
            out_reg.hop_index      <= found_reg ? 4'(best_slot_reg) : 4'd0;
            out_reg.hop_score      <= found_reg ? 26'(best_score_reg) : 26'd0;
            out_reg.neighbor_total <= 5'(count_reg);
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

// ===== hdl/ntnh_controller.sv =====
`default_nettype none
module ntnh_controller (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire              m_ready,
    output ntnh_pkg::cmd_t   cmd,
    input  ntnh_pkg::stat_t  stat
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOOK  = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd.look = 1'b1;
                if (stat.look_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// ===== hdl/neighbor_trust_table_next_hop.sv =====
`default_nettype none
// channel  direction  ports                        payload
// input    in         s_valid s_ready s_data       in_item_t
// result   out        m_valid m_ready m_data       out_item_t
// config   in         cfg_we cfg_index cfg_data    16 bit write, no read-back
//
// with N entries before a request, the lookup reads one slot per cycle and
// stops after a hit, then the score scan reads every slot once more; the
// next request can be taken as soon as the result is loaded into the
// output register.
// reset empties the table at once (entry count cleared), no clearing pass.
// a finished result waits in the output register; the next request is taken
// meanwhile and waits at its end until the output register is free.
module neighbor_trust_table_next_hop #(
    parameter int TABLE_ENTRIES       = ntnh_pkg::TABLE_ENTRIES_DEF,
    parameter int TRUST_FRACTION_BITS = ntnh_pkg::TRUST_FRAC_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  ntnh_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  wire                             m_ready,
    output ntnh_pkg::out_item_t             m_data,
    input  wire                             cfg_we,
    input  wire [ntnh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [ntnh_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ntnh_pkg::cmd_t  cmd;
    ntnh_pkg::stat_t stat;

    ntnh_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    ntnh_datapath #(
        .TABLE_ENTRIES       (TABLE_ENTRIES),
        .TRUST_FRACTION_BITS (TRUST_FRACTION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_data)
    );

    // a request is worked on alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in work");

    // no route means zeroed hop fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.route_found |->
            m_data.hop_address == 16'd0 && m_data.hop_index == 4'd0
            && m_data.hop_score == 26'd0)
        else $error("hop fields set without a route");

    // status code is one of the defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.update_status == ntnh_pkg::STATUS_UPDATED
            || m_data.update_status == ntnh_pkg::STATUS_ADDED
            || m_data.update_status == ntnh_pkg::STATUS_FULL)
        else $error("undefined update status");

    // full status only with a full table
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.update_status == ntnh_pkg::STATUS_FULL |->
            m_data.neighbor_total == 5'(TABLE_ENTRIES))
        else $error("table full reported below capacity");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 48;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 170;

    localparam int SLOTS = ntnh_pkg::TABLE_ENTRIES_DEF;
    localparam logic [11:0] TRUST_ONE = 12'd1 << ntnh_pkg::TRUST_FRAC_DEF;
    localparam logic [ntnh_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #CLK_HALF aclk = ~aclk;

    // block ports
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    ntnh_pkg::in_item_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    ntnh_pkg::out_item_t             m_data;
    logic                            cfg_we    = 1'b0;
    logic [ntnh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ntnh_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    neighbor_trust_table_next_hop dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // hello requests waiting to be sent, next hop results waiting to arrive
    ntnh_pkg::in_item_t  hello_q[$];
    ntnh_pkg::out_item_t next_hop_q[$];

    int send_idle_pct = 21;
    int recv_idle_pct = 74;
    bit hold_req      = 1'b0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    // shadow neighbor table and registers
    logic [15:0] tbl_addr   [SLOTS];
    logic [10:0] tbl_trust  [SLOTS];
    logic [15:0] tbl_energy [SLOTS];
    logic [4:0]  tbl_count;
    logic [15:0] thr_energy;
    logic [10:0] thr_trust;
    logic [10:0] trust_inc;

    // update the shadow table with one hello and pick the next hop
    function automatic ntnh_pkg::out_item_t predict_hop(ntnh_pkg::in_item_t h);
        ntnh_pkg::out_item_t r;
        logic [1:0]  status;
        logic [4:0]  slot;
        logic        hit;
        logic [11:0] t;
        logic [26:0] score;
        logic [26:0] best;
        logic [4:0]  best_slot;
        logic        found;
        status    = ntnh_pkg::STATUS_FULL;
        slot      = '0;
        hit       = 1'b0;
        best      = '0;
        best_slot = '0;
        found     = 1'b0;
        // lookup, then append when unknown and there is room
        for (int i = 0; i < tbl_count; i++) begin
            if (!hit && tbl_addr[i] == h.neighbor_address) begin
                slot   = 5'(i);
                hit    = 1'b1;
                status = ntnh_pkg::STATUS_UPDATED;
            end
        end
        if (!hit && tbl_count < SLOTS) begin
            slot           = tbl_count;
            tbl_addr[slot] = h.neighbor_address;
            tbl_count      = tbl_count + 5'd1;
            hit            = 1'b1;
            status         = ntnh_pkg::STATUS_ADDED;
        end
        // store energy, raise trust and clamp at one
        if (hit) begin
            t = {1'b0, h.neighbor_trust} + {1'b0, trust_inc};
            if (t > TRUST_ONE)
                t = TRUST_ONE;
            tbl_energy[slot] = h.neighbor_energy;
            tbl_trust[slot]  = t[10:0];
        end
        // best eligible score, lowest slot wins a tie
        for (int i = 0; i < tbl_count; i++) begin
            score = 27'(tbl_trust[i]) * 27'(tbl_energy[i]);
            if (tbl_trust[i] > thr_trust && tbl_energy[i] > thr_energy) begin
                if (!found || score > best) begin
                    found     = 1'b1;
                    best      = score;
                    best_slot = 5'(i);
                end
            end
        end
        r.update_status  = status;
        r.low_energy     = h.neighbor_energy < thr_energy;
        r.route_found    = found;
        r.hop_address    = found ? tbl_addr[best_slot] : 16'd0;
        r.hop_index      = found ? best_slot[3:0] : 4'd0;
        r.hop_score      = found ? best[25:0] : 26'd0;
        r.neighbor_total = tbl_count;
        return r;
    endfunction

    function automatic ntnh_pkg::in_item_t hello(logic [15:0] addr, logic [15:0] energy,
                                                 logic [10:0] trust);
        ntnh_pkg::in_item_t h;
        h.neighbor_address = addr;
        h.neighbor_energy  = energy;
        h.neighbor_trust   = trust;
        return h;
    endfunction

    // mostly known neighbors, values clustered around the thresholds
    function automatic ntnh_pkg::in_item_t random_hello();
        ntnh_pkg::in_item_t h;
        if ($urandom_range(99, 0) < 70 && tbl_count != 0)
            h.neighbor_address = tbl_addr[4'($urandom_range(tbl_count - 1, 0))];
        else
            h.neighbor_address = 16'($urandom);
        case ($urandom_range(3, 0))
            0: h.neighbor_energy = 16'($urandom_range(40, 0));
            1: h.neighbor_energy = thr_energy + 16'($urandom_range(2, 0)) - 16'd1;
            2: h.neighbor_energy = 16'($urandom_range(65535, 60000));
            default: h.neighbor_energy = 16'($urandom);
        endcase
        case ($urandom_range(3, 0))
            0: h.neighbor_trust = 11'($urandom_range(1024, 0));
            1: h.neighbor_trust = thr_trust - trust_inc + 11'($urandom_range(2, 0)) - 11'd1;
            2: h.neighbor_trust = 11'($urandom_range(2047, 0));
            default: h.neighbor_trust = TRUST_ONE[10:0];
        endcase
        return h;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (hello_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= hello_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and a long hold-off on request
    int  hold_left = 0;
    bit  hold_seen = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99, 0) >= recv_idle_pct;
        end
    end

    // monitor: check results, then predict accepted requests
    always @(posedge aclk) begin : monitor
        ntnh_pkg::out_item_t want;
        logic                moved;
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            moved = 1'b0;
            if (m_valid === 1'b1 && m_ready) begin
                moved = 1'b1;
                if (next_hop_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with nothing pending: %p", $realtime, m_data);
                end else begin
                    want = next_hop_q.pop_front();
                    if (m_data.update_status !== want.update_status
                        || m_data.low_energy !== want.low_energy
                        || m_data.route_found !== want.route_found
                        || m_data.hop_address !== want.hop_address
                        || m_data.hop_index !== want.hop_index
                        || m_data.hop_score !== want.hop_score
                        || m_data.neighbor_total !== want.neighbor_total) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: mismatch status/low/found/addr/idx/score/total",
                                     $realtime);
                            $display("  expected %0d %b %b %h %0d %0d %0d",
                                     want.update_status, want.low_energy, want.route_found,
                                     want.hop_address, want.hop_index, want.hop_score,
                                     want.neighbor_total);
                            $display("  actual   %0d %b %b %h %0d %0d %0d",
                                     m_data.update_status, m_data.low_energy,
                                     m_data.route_found, m_data.hop_address,
                                     m_data.hop_index, m_data.hop_score,
                                     m_data.neighbor_total);
                        end
                    end
                end
            end
            if (s_valid && s_ready === 1'b1) begin
                moved = 1'b1;
                next_hop_q.push_back(predict_hop(s_data));
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // watchdog on cycles with no handshake
    initial begin
        @(posedge aresetn);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic write_reg(logic [ntnh_pkg::CFG_IDX_W-1:0] idx,
                             logic [ntnh_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            ntnh_pkg::CFG_ENERGY_THRESHOLD: thr_energy = val;
            ntnh_pkg::CFG_TRUST_THRESHOLD:  thr_trust  = val[10:0];
            ntnh_pkg::CFG_TRUST_INCREMENT:  trust_inc  = val[10:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // wait until every queued request is sent and every pending result is back
    task automatic wait_drained();
        while (hello_q.size() != 0 || s_valid || next_hop_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(logic [15:0] e_thr, logic [15:0] t_thr, logic [15:0] inc,
                             int s_idle, int r_idle, bit long_hold);
        wait_drained();
        write_reg(ntnh_pkg::CFG_ENERGY_THRESHOLD, e_thr);
        write_reg(ntnh_pkg::CFG_TRUST_THRESHOLD, t_thr);
        write_reg(ntnh_pkg::CFG_TRUST_INCREMENT, inc);
        write_reg(CFG_UNUSED_INDEX, 16'($urandom));
        send_idle_pct <= s_idle;
        recv_idle_pct <= r_idle;
        @(negedge aclk);
        repeat (PHASE_ITEMS) hello_q.push_back(random_hello());
        if (long_hold) begin
            @(posedge aclk);
            hold_req <= ~hold_req;
        end
    endtask

    // stimulus
    initial begin
        tbl_count  = '0;
        thr_energy = ntnh_pkg::ENERGY_THRESHOLD_RST;
        thr_trust  = ntnh_pkg::TRUST_THRESHOLD_RST;
        trust_inc  = ntnh_pkg::TRUST_INCREMENT_RST;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed requests at reset settings
        hello_q.push_back(hello(16'h0000, 16'd0, 11'd0));        // zero everything, low energy
        hello_q.push_back(hello(16'hFFFF, 16'hFFFF, 11'd1024));  // largest score, trust clamped
        hello_q.push_back(hello(16'h0001, 16'd9, 11'd600));      // energy just under threshold
        hello_q.push_back(hello(16'h0002, 16'd10, 11'd700));     // energy at threshold
        hello_q.push_back(hello(16'h0003, 16'd11, 11'd503));     // trust just over threshold
        hello_q.push_back(hello(16'h0004, 16'd500, 11'h7FF));    // trust above one
        hello_q.push_back(hello(16'h0005, 16'd500, 11'h7FF));    // same score, tie
        hello_q.push_back(hello(16'hFFFF, 16'd0, 11'd0));        // update drops the leader
        for (int i = 0; i < 9; i++)
            hello_q.push_back(hello(16'h0100 + 16'(i * 16'h0111), 16'($urandom),
                                    11'($urandom_range(1024, 0))));
        hello_q.push_back(hello(16'h8000, 16'd1000, 11'd900));   // table full
        hello_q.push_back(hello(16'h5555, 16'hAAAA, 11'h2AA));   // table full, bit pattern
        hello_q.push_back(hello(16'h0003, 16'd11, 11'd502));     // trust lands on threshold
        hello_q.push_back(hello(16'h0003, 16'd11, 11'd503));
        repeat (150) hello_q.push_back(random_hello());

        // settings phases: extremes and mid values, then random values and reset values
        run_phase(16'd0, 16'd0, 16'd0, 21, 74, 1'b1);
        run_phase(16'hFFFF, 16'h07FF, 16'h07FF, 21, 74, 1'b0);
        run_phase(16'd300, 16'd1023, 16'd1, 74, 21, 1'b0);
        run_phase(16'hFFFF, 16'd1024, 16'd1024, 74, 21, 1'b1);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 0, 0, 1'b0);
        run_phase(16'd10, 16'd512, 16'd10, 0, 0, 1'b0);

        wait_drained();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
